[rtl/firmata_receive_parser_top_defines.svh]
// Assertion macros for the Firmata receive parser
`ifndef FIRMATA_RECEIVE_PARSER_TOP_DEFINES_SVH
`define FIRMATA_RECEIVE_PARSER_TOP_DEFINES_SVH
`define FRP_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define FRP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

[rtl/frp_pkg.sv]
// Package: widths, item types, constants for the Firmata receive parser
`default_nettype none
package frp_pkg;
  localparam int PIN_COUNT = 128;
  localparam int BUFFER_DEPTH = 4096;
  localparam int MODE_BITS = 16;
  localparam int PIN_W = $clog2(PIN_COUNT);
  localparam int BUF_AW = $clog2(BUFFER_DEPTH);
  localparam int CNT_W = BUF_AW + 1;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_MODE = 2'd2;

  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_ANALOG = 3'd1;
  localparam logic [2:0] K_DIGITAL = 3'd2;
  localparam logic [2:0] K_FIRMWARE = 3'd3;
  localparam logic [2:0] K_CAPAB = 3'd4;
  localparam logic [2:0] K_AMAP = 3'd5;
  localparam logic [2:0] K_PSTATE = 3'd6;
  localparam logic [2:0] K_IGNORED = 3'd7;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [6:0] pin_index;
    logic [7:0] new_mode;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  msg_kind;
    logic [6:0]  msg_channel;
    logic [20:0] msg_value;
    logic [6:0]  fw_major;
    logic [6:0]  fw_minor;
    logic        board_ready;
    logic [7:0]  rd_mode;
    logic [6:0]  rd_analog_channel;
    logic [15:0] rd_supported_modes;
    logic [20:0] rd_value;
    logic        rd_ready;
  } out_item_t;

  typedef struct packed {
    logic [7:0]           mode;
    logic [6:0]           chan;
    logic [MODE_BITS-1:0] cap;
    logic [20:0]          value;
    logic                 rdy;
  } pin_entry_t;
endpackage
`default_nettype wire

[rtl/firmata_receive_parser_top.sv]
// Firmata receive parser: byte sequencer, message decode and pin table walks
//  channel | dir | payload     | handshake
//  in      | in  | in_item_t   | in_valid / in_stall
//  out     | out | out_item_t  | out_valid / out_stall
// Every accepted item yields one result; the next item can be taken in the cycle after the
// result is taken. A completed message first fetches header bytes (more for sysex), then
// its walk: analog scans pins for its channel, digital visits 8 pins, capability and analog
// map step through buffer bytes. The table has one port, the buffer one write, one read.
// Synchronous reset clears control state and table valid bits at once, no sweep.
// The output register holds a result while out_stall is high; no input is taken then.
`default_nettype none
module firmata_receive_parser_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire frp_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output frp_pkg::out_item_t       out_data
);
  localparam int PW = frp_pkg::PIN_W;
  localparam int AW = frp_pkg::BUF_AW;
  localparam int CW = frp_pkg::CNT_W;
  localparam int MB = frp_pkg::MODE_BITS;

  typedef enum logic [4:0] {
    S_IDLE, S_TAKE, S_RDW, S_RD, S_MW, S_MD,
    S_H0, S_H1, S_H2, S_DEC,
    S_AN_R, S_AN_W, S_AN_C,
    S_DG_R, S_DG_W,
    S_SX1, S_SX2, S_SXD,
    S_FW,
    S_CP_R, S_CP_W, S_CP_B,
    S_AM_R, S_AM_W, S_AM_B,
    S_PS_R, S_PS_W,
    S_DONE
  } state_t;

  state_t state;
  frp_pkg::in_item_t it;
  frp_pkg::out_item_t res;
  logic [CW-1:0] cnt, explen, idx;
  logic [7:0] head, b1, b2, b3, b4, b5, b6, last, sub;
  logic [7:0] pin;
  logic half;
  logic [6:0] fwmaj, fwmin;
  logic rflag;
  logic [2:0] dig;

  logic buf_we;
  logic [AW-1:0] buf_wa, buf_ra;
  logic [7:0] buf_rd;
  logic tbl_we, cap_clr;
  logic [PW-1:0] tbl_a;
  frp_pkg::pin_entry_t tbl_wd, tbl_rd;

  frp_buffer u_buf (.clk, .we(buf_we), .waddr(buf_wa), .wdata(it.rx_byte),
                    .raddr(buf_ra), .rdata(buf_rd));
  frp_pin_table u_tbl (.clk, .rst, .we(tbl_we), .addr(tbl_a), .wdata(tbl_wd),
                       .cap_clear(cap_clr), .rdata(tbl_rd));

  assign in_stall = (state != S_IDLE) || out_valid;

  logic [7:0] hi;
  logic [CW-1:0] cnt_new, exp_new;
  logic [14:0] v15;
  logic [20:0] pv;
  logic [3:0] port;
  logic [7:0] dpin;
  assign hi = it.rx_byte & 8'hF0;
  assign v15 = {b2, 7'b0} | {7'b0, b1};
  assign port = head[3:0];
  assign dpin = {1'b0, port, dig};
  assign pv = ({13'b0, b4}
               | ((cnt > CW'(6)) ? {6'b0, b5, 7'b0} : 21'b0)
               | ((cnt > CW'(7)) ? {b6[6:0], 14'b0} : 21'b0));

  always_comb begin
    cnt_new = cnt;
    exp_new = explen;
    if (hi == 8'hE0 || hi == 8'h90 || it.rx_byte == 8'hF9) begin
      exp_new = CW'(3); cnt_new = '0;
    end else if (hi == 8'hC0 || hi == 8'hD0) begin
      exp_new = CW'(2); cnt_new = '0;
    end else if (it.rx_byte == 8'hF0) begin
      exp_new = CW'(frp_pkg::BUFFER_DEPTH); cnt_new = '0;
    end else if (it.rx_byte == 8'hF7) begin
      exp_new = cnt + CW'(1);
    end else if (it.rx_byte[7]) begin
      exp_new = CW'(1); cnt_new = '0;
    end
  end

  always_comb begin
    buf_we = 1'b0;
    buf_wa = cnt_new[AW-1:0];
    buf_ra = idx[AW-1:0];
    tbl_we = 1'b0;
    cap_clr = 1'b0;
    tbl_a = it.pin_index[PW-1:0];
    tbl_wd = tbl_rd;
    unique case (state)
      S_TAKE: buf_we = (cnt_new < CW'(frp_pkg::BUFFER_DEPTH));
      S_MW, S_RDW: tbl_a = it.pin_index[PW-1:0];
      S_MD: begin
        tbl_a = it.pin_index[PW-1:0];
        tbl_we = rflag && {1'b0, it.pin_index} < 8'(frp_pkg::PIN_COUNT)
                 && it.new_mode != tbl_rd.mode;
        tbl_wd.mode = it.new_mode;
        tbl_wd.value = '0;
      end
      S_AN_R, S_AN_W: tbl_a = idx[PW-1:0];
      S_AN_C: begin
        tbl_a = idx[PW-1:0];
        tbl_we = 1'b1;
        tbl_wd.value = {6'b0, v15};
        tbl_wd.rdy = 1'b1;
      end
      S_DG_R, S_DG_W: begin
        tbl_a = dpin[PW-1:0];
        if (state == S_DG_W && dpin < 8'(frp_pkg::PIN_COUNT) && tbl_rd.mode == 8'd0
            && tbl_rd.value != {20'b0, v15[dig]}) begin
          tbl_we = 1'b1;
          tbl_wd.value = {20'b0, v15[dig]};
          tbl_wd.rdy = 1'b1;
        end
      end
      S_CP_R, S_CP_W, S_CP_B: begin
        tbl_a = pin[PW-1:0];
        if (state == S_CP_B && buf_rd != 8'd127 && !half && pin < 8'(frp_pkg::PIN_COUNT)
            && buf_rd < 8'(MB)) begin
          tbl_we = 1'b1;
          tbl_wd.cap = tbl_rd.cap | (MB'(1) << buf_rd[$clog2(MB)-1:0]);
        end
      end
      S_AM_R, S_AM_W, S_AM_B: begin
        tbl_a = pin[PW-1:0];
        if (state == S_AM_B && pin < 8'(frp_pkg::PIN_COUNT)) begin
          tbl_we = 1'b1;
          tbl_wd.chan = buf_rd[6:0];
        end
      end
      S_PS_R, S_PS_W: begin
        tbl_a = b2[PW-1:0];
        if (state == S_PS_W && {1'b0, b2[6:0]} < 8'(frp_pkg::PIN_COUNT)) begin
          tbl_we = 1'b1;
          tbl_wd.mode = b3;
          tbl_wd.value = pv;
        end
      end
      default: ;
    endcase
    if (state == S_SXD && sub == 8'h6C) cap_clr = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cnt <= '0;
      explen <= '0;
      fwmaj <= '0;
      fwmin <= '0;
      rflag <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid && !in_stall) begin
          it <= in_data;
          res <= '0;
          unique case (in_data.op)
            frp_pkg::OP_BYTE: state <= S_TAKE;
            frp_pkg::OP_READ: state <= S_RDW;
            frp_pkg::OP_MODE: state <= S_MW;
            default: state <= S_DONE;
          endcase
        end
        S_RDW: state <= S_RD;
        S_RD: begin
          if ({1'b0, it.pin_index} < 8'(frp_pkg::PIN_COUNT)) begin
            res.rd_mode <= tbl_rd.mode;
            res.rd_analog_channel <= tbl_rd.chan;
            res.rd_supported_modes <= 16'(tbl_rd.cap);
            res.rd_value <= tbl_rd.value;
            res.rd_ready <= tbl_rd.rdy;
          end else begin
            res.rd_mode <= 8'hFF;
            res.rd_analog_channel <= 7'h7F;
          end
          state <= S_DONE;
        end
        S_MW: state <= S_MD;
        S_MD: state <= S_DONE;
        S_TAKE: begin
          explen <= exp_new;
          if (cnt_new < CW'(frp_pkg::BUFFER_DEPTH)) begin
            if (cnt_new + CW'(1) == exp_new) begin
              cnt <= cnt_new + CW'(1);
              idx <= '0;
              state <= S_H0;
            end else begin
              cnt <= cnt_new + CW'(1);
              state <= S_DONE;
            end
          end else begin
            cnt <= cnt_new;
            if (cnt_new == exp_new) begin
              idx <= '0;
              state <= S_H0;
            end else state <= S_DONE;
          end
        end
        S_H0: begin idx <= CW'(1); state <= S_H1; end
        S_H1: begin head <= buf_rd; idx <= CW'(2); state <= S_H2; end
        S_H2: begin b1 <= buf_rd; idx <= cnt - CW'(1); state <= S_DEC; end
        S_DEC: begin
          b2 <= buf_rd;
          if ((head & 8'hF0) == 8'hE0 && cnt == CW'(3)) begin
            res.msg_kind <= frp_pkg::K_ANALOG;
            res.msg_channel <= {3'b0, head[3:0]};
            res.msg_value <= {6'b0, buf_rd, 7'b0} | {13'b0, b1};
            idx <= '0;
            state <= S_AN_R;
          end else if ((head & 8'hF0) == 8'h90 && cnt == CW'(3)) begin
            res.msg_kind <= frp_pkg::K_DIGITAL;
            res.msg_channel <= {3'b0, head[3:0]};
            res.msg_value <= {6'b0, buf_rd, 7'b0} | {13'b0, b1};
            dig <= '0;
            state <= S_DG_R;
          end else begin
            idx <= CW'(2);
            state <= S_SX1;
          end
        end
        S_SX1: begin last <= buf_rd; idx <= CW'(3); state <= S_SX2; end
        S_SX2: begin b2 <= buf_rd; idx <= CW'(4); state <= S_SXD; sub <= b1; end
        S_SXD: begin
          if (!(cnt >= CW'(2) && head == 8'hF0 && last == 8'hF7)) begin
            res.msg_kind <= frp_pkg::K_IGNORED;
            state <= S_DONE;
          end else if (sub == 8'h79) begin
            b3 <= buf_rd;
            state <= S_FW;
          end else if (sub == 8'h6C) begin
            pin <= '0; half <= 1'b0; idx <= CW'(2);
            res.msg_kind <= frp_pkg::K_CAPAB;
            state <= S_CP_R;
          end else if (sub == 8'h6A) begin
            pin <= '0; idx <= CW'(2);
            res.msg_kind <= frp_pkg::K_AMAP;
            state <= S_AM_R;
          end else if (sub == 8'h6E && cnt >= CW'(6)) begin
            b3 <= buf_rd; idx <= CW'(4);
            state <= S_PS_R;
          end else begin
            res.msg_kind <= frp_pkg::K_IGNORED;
            state <= S_DONE;
          end
        end
        S_FW: begin
          fwmaj <= (cnt >= CW'(4)) ? b2[6:0] : 7'd0;
          fwmin <= (cnt >= CW'(5)) ? b3[6:0] : 7'd0;
          rflag <= 1'b1;
          res.msg_kind <= frp_pkg::K_FIRMWARE;
          state <= S_DONE;
        end
        S_AN_R: state <= S_AN_W;
        S_AN_W: begin
          if (tbl_rd.chan == {3'b0, head[3:0]}) state <= S_AN_C;
          else if (idx == CW'(frp_pkg::PIN_COUNT - 1)) state <= S_DONE;
          else begin idx <= idx + CW'(1); state <= S_AN_R; end
        end
        S_AN_C: state <= S_DONE;
        S_DG_R: state <= S_DG_W;
        S_DG_W: begin
          if (dig == 3'd7) state <= S_DONE;
          else begin dig <= dig + 3'd1; state <= S_DG_R; end
        end
        S_CP_R: begin
          if (idx + CW'(1) >= cnt) state <= S_DONE;
          else state <= S_CP_W;
        end
        S_CP_W: state <= S_CP_B;
        S_CP_B: begin
          if (buf_rd == 8'd127) begin
            if (pin < 8'(frp_pkg::PIN_COUNT)) pin <= pin + 8'd1;
            half <= 1'b0;
          end else half <= ~half;
          idx <= idx + CW'(1);
          state <= S_CP_R;
        end
        S_AM_R: begin
          if (idx + CW'(1) >= cnt) state <= S_DONE;
          else state <= S_AM_W;
        end
        S_AM_W: state <= S_AM_B;
        S_AM_B: begin
          if (pin < 8'(frp_pkg::PIN_COUNT)) pin <= pin + 8'd1;
          idx <= idx + CW'(1);
          state <= S_AM_R;
        end
        S_PS_R: begin b4 <= buf_rd; idx <= CW'(5); state <= S_PS_W; end
        S_PS_W: begin
          if (idx == CW'(5)) begin idx <= CW'(6); state <= S_PS_W; end
          else if (idx == CW'(6)) begin b5 <= buf_rd; idx <= CW'(7); state <= S_PS_W; end
          else if (idx == CW'(7)) begin
            b6 <= buf_rd; idx <= CW'(8); state <= S_PS_W;
          end else begin
            res.msg_kind <= frp_pkg::K_PSTATE;
            res.msg_channel <= b2[6:0];
            res.msg_value <= pv;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res.msg_kind != frp_pkg::K_NONE && it.op == frp_pkg::OP_BYTE) begin
            cnt <= '0;
            explen <= '0;
          end
          out_data <= {res.msg_kind, res.msg_channel, res.msg_value, fwmaj, fwmin, rflag,
                       res.rd_mode, res.rd_analog_channel, res.rd_supported_modes,
                       res.rd_value, res.rd_ready};
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[rtl/frp_buffer.sv]
// Message byte buffer: one write port, one registered read port
`default_nettype none
module frp_buffer (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [frp_pkg::BUF_AW-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic [frp_pkg::BUF_AW-1:0] raddr,
  output logic      [7:0]                rdata
);
  logic [7:0] mem [frp_pkg::BUFFER_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/frp_pin_table.sv]
// Pin table: one port, registered read, per-pin valid bits give reset values
`default_nettype none
module frp_pin_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       we,
  input  wire logic [frp_pkg::PIN_W-1:0]  addr,
  input  wire frp_pkg::pin_entry_t        wdata,
  input  wire logic                       cap_clear,
  output frp_pkg::pin_entry_t             rdata
);
  frp_pkg::pin_entry_t mem [frp_pkg::PIN_COUNT];
  logic [frp_pkg::PIN_COUNT-1:0] vld;
  logic [frp_pkg::PIN_COUNT-1:0] capv;
  frp_pkg::pin_entry_t raw;
  logic rv, rcv;

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    raw <= mem[addr];
    rv <= vld[addr];
    rcv <= capv[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      capv <= '0;
    end else begin
      if (cap_clear) capv <= '0;
      if (we) begin
        vld[addr] <= 1'b1;
        capv[addr] <= 1'b1;
      end
    end
  end

  always_comb begin
    rdata = raw;
    if (!rv) begin
      rdata.mode = 8'hFF;
      rdata.chan = 7'h7F;
      rdata.value = '0;
      rdata.rdy = 1'b0;
    end
    if (!rv || !rcv) rdata.cap = '0;
  end
endmodule
`default_nettype wire

[rtl/frp_checker.sv]
// Port checker for the Firmata receive parser, bound to the top level
`include "firmata_receive_parser_top_defines.svh"
`default_nettype none
module frp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire frp_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire frp_pkg::out_item_t out_data
);
  `FRP_ASSERT_IMPL(a_hold, clk, rst, out_valid && out_stall, 1'b1)
  `FRP_ASSERT_NEXT(a_stable, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `FRP_ASSERT_NEXT(a_busy, clk, rst, in_valid && !in_stall, in_stall)
  `FRP_ASSERT_IMPL(a_rdy, clk, rst, out_valid && !out_data.board_ready, out_data.fw_major == 7'd0)
endmodule
bind firmata_receive_parser_top frp_checker u_chk (.*);
`default_nettype wire

[test/testbench.sv]
// Testbench for the Firmata receive parser: predicted pin table, checked result stream
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_END      = 8'hF7;
  localparam logic [7:0] ST_ANALOG   = 8'hE0;
  localparam logic [7:0] ST_DIGITAL  = 8'h90;
  localparam logic [7:0] ST_VERSION  = 8'hF9;
  localparam logic [7:0] ST_PROGRAM  = 8'hC0;
  localparam logic [7:0] ST_PRESSURE = 8'hD0;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] SX_AMAP     = 8'h6A;
  localparam logic [7:0] SX_CAPAB    = 8'h6C;
  localparam logic [7:0] SX_PSTATE   = 8'h6E;
  localparam logic [7:0] SX_FIRMWARE = 8'h79;
  localparam logic [7:0] CAP_PIN_END = 8'h7F;
  localparam int STALL_LIMIT = 20000;

  class pin_table_tracker;
    logic [7:0]                    mode_tbl[frp_pkg::PIN_COUNT];
    logic [6:0]                    chan_tbl[frp_pkg::PIN_COUNT];
    logic [frp_pkg::MODE_BITS-1:0] cap_tbl[frp_pkg::PIN_COUNT];
    logic [20:0]                   val_tbl[frp_pkg::PIN_COUNT];
    logic                          rdy_tbl[frp_pkg::PIN_COUNT];
    logic [7:0]                    msg_buf[frp_pkg::BUFFER_DEPTH];
    int unsigned                   byte_cnt, want_len;
    logic                          board_up;
    logic [6:0]                    fw_maj, fw_min;
    frp_pkg::out_item_t            res;
    frp_pkg::out_item_t            pending_results[$];
    int                            mismatches, results_seen;
    int                            kinds_seen[8];

    function new();
      foreach (mode_tbl[i]) begin
        mode_tbl[i] = 8'hFF;
        chan_tbl[i] = 7'h7F;
        cap_tbl[i] = '0;
        val_tbl[i] = '0;
        rdy_tbl[i] = 1'b0;
      end
      byte_cnt = 0;
      want_len = 0;
      board_up = 1'b0;
      fw_maj = '0;
      fw_min = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    task report(string what);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function void finish_sysex(int unsigned n);
      logic [7:0]  sub, b;
      int unsigned pin, half;
      logic [20:0] v;
      logic [6:0]  p;
      sub = msg_buf[1];
      if (sub == SX_FIRMWARE) begin
        fw_maj = (n >= 4) ? msg_buf[2][6:0] : 7'd0;
        fw_min = (n >= 5) ? msg_buf[3][6:0] : 7'd0;
        board_up = 1'b1;
        res.msg_kind = frp_pkg::K_FIRMWARE;
      end else if (sub == SX_CAPAB) begin
        foreach (cap_tbl[i]) cap_tbl[i] = '0;
        pin = 0;
        half = 0;
        for (int unsigned i = 2; i + 1 < n; i++) begin
          b = msg_buf[i];
          if (b == CAP_PIN_END) begin
            if (pin < frp_pkg::PIN_COUNT) pin++;
            half = 0;
          end else begin
            if (half == 0 && pin < frp_pkg::PIN_COUNT && b < frp_pkg::MODE_BITS)
              cap_tbl[pin][b] = 1'b1;
            half ^= 1;
          end
        end
        res.msg_kind = frp_pkg::K_CAPAB;
      end else if (sub == SX_AMAP) begin
        pin = 0;
        for (int unsigned i = 2; i + 1 < n; i++) begin
          if (pin < frp_pkg::PIN_COUNT) chan_tbl[pin] = msg_buf[i][6:0];
          pin++;
        end
        res.msg_kind = frp_pkg::K_AMAP;
      end else if (sub == SX_PSTATE && n >= 6) begin
        p = msg_buf[2][6:0];
        v = 21'(msg_buf[4]);
        if (n > 6) v |= 21'(msg_buf[5]) << 7;
        if (n > 7) v |= 21'(msg_buf[6]) << 14;
        mode_tbl[p] = msg_buf[3];
        val_tbl[p] = v;
        res.msg_kind = frp_pkg::K_PSTATE;
        res.msg_channel = p;
        res.msg_value = v;
      end else begin
        res.msg_kind = frp_pkg::K_IGNORED;
      end
    endfunction

    function void finish_message();
      logic [7:0]  head;
      logic [20:0] v;
      int unsigned n, p;
      head = msg_buf[0];
      n = byte_cnt;
      v = 21'(msg_buf[1]) | (21'(msg_buf[2]) << 7);
      if ((head & 8'hF0) == ST_ANALOG && n == 3) begin
        for (int i = 0; i < frp_pkg::PIN_COUNT; i++)
          if (chan_tbl[i] == 7'(head[3:0])) begin
            val_tbl[i] = v;
            rdy_tbl[i] = 1'b1;
            break;
          end
        res.msg_kind = frp_pkg::K_ANALOG;
        res.msg_channel = 7'(head[3:0]);
        res.msg_value = v;
      end else if ((head & 8'hF0) == ST_DIGITAL && n == 3) begin
        for (int i = 0; i < 8; i++) begin
          p = head[3:0] * 8 + i;
          if (p < frp_pkg::PIN_COUNT && mode_tbl[p] == 8'd0 && val_tbl[p] != 21'(v[i])) begin
            val_tbl[p] = 21'(v[i]);
            rdy_tbl[p] = 1'b1;
          end
        end
        res.msg_kind = frp_pkg::K_DIGITAL;
        res.msg_channel = 7'(head[3:0]);
        res.msg_value = v;
      end else if (n >= 2 && n <= frp_pkg::BUFFER_DEPTH && head == ST_SYSEX
                   && msg_buf[n-1] == ST_END) begin
        finish_sysex(n);
      end else begin
        res.msg_kind = frp_pkg::K_IGNORED;
      end
    endfunction

    function void take_rx(logic [7:0] b);
      logic [7:0] hi;
      hi = b & 8'hF0;
      if (hi == ST_ANALOG || hi == ST_DIGITAL || b == ST_VERSION) begin
        want_len = 3; byte_cnt = 0;
      end else if (hi == ST_PROGRAM || hi == ST_PRESSURE) begin
        want_len = 2; byte_cnt = 0;
      end else if (b == ST_SYSEX) begin
        want_len = frp_pkg::BUFFER_DEPTH; byte_cnt = 0;
      end else if (b == ST_END) begin
        want_len = byte_cnt + 1;
      end else if (b[7]) begin
        want_len = 1; byte_cnt = 0;
      end
      if (byte_cnt < frp_pkg::BUFFER_DEPTH) begin
        msg_buf[byte_cnt] = b;
        byte_cnt++;
      end
      if (byte_cnt == want_len) begin
        finish_message();
        byte_cnt = 0;
        want_len = 0;
      end
    endfunction

    function void note_item(frp_pkg::in_item_t it);
      res = '0;
      case (it.op)
        frp_pkg::OP_BYTE: take_rx(it.rx_byte);
        frp_pkg::OP_READ: begin
          res.rd_mode = mode_tbl[it.pin_index];
          res.rd_analog_channel = chan_tbl[it.pin_index];
          res.rd_supported_modes = cap_tbl[it.pin_index];
          res.rd_value = val_tbl[it.pin_index];
          res.rd_ready = rdy_tbl[it.pin_index];
        end
        frp_pkg::OP_MODE:
          if (board_up && it.new_mode != mode_tbl[it.pin_index]) begin
            mode_tbl[it.pin_index] = it.new_mode;
            val_tbl[it.pin_index] = '0;
          end
        default: ;
      endcase
      res.fw_major = fw_maj;
      res.fw_minor = fw_min;
      res.board_ready = board_up;
      pending_results = {pending_results, res};
    endfunction

    task cmp(string field, longint unsigned got, longint unsigned want);
      if (got != want)
        report($sformatf("result %0d %s got 0x%0h want 0x%0h", results_seen, field, got, want));
    endtask

    task check_result(frp_pkg::out_item_t got);
      frp_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      want = pending_results.pop_front();
      cmp("msg_kind", got.msg_kind, want.msg_kind);
      cmp("msg_channel", got.msg_channel, want.msg_channel);
      cmp("msg_value", got.msg_value, want.msg_value);
      cmp("fw_major", got.fw_major, want.fw_major);
      cmp("fw_minor", got.fw_minor, want.fw_minor);
      cmp("board_ready", got.board_ready, want.board_ready);
      cmp("rd_mode", got.rd_mode, want.rd_mode);
      cmp("rd_analog_channel", got.rd_analog_channel, want.rd_analog_channel);
      cmp("rd_supported_modes", got.rd_supported_modes, want.rd_supported_modes);
      cmp("rd_value", got.rd_value, want.rd_value);
      cmp("rd_ready", got.rd_ready, want.rd_ready);
      kinds_seen[want.msg_kind]++;
      results_seen++;
    endtask
  endclass

  logic               clk, rst;
  logic               in_valid, in_stall, out_valid, out_stall;
  frp_pkg::in_item_t  in_data;
  frp_pkg::out_item_t out_data;
  int                 gap_pct, stall_pct, items_sent, idle_cycles;
  pin_table_tracker   tracker;

  firmata_receive_parser_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    idle_cycles = 0;
    tracker = new();
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) tracker.note_item(in_data);
    if (!rst && out_valid && !out_stall) tracker.check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_item(frp_pkg::in_item_t it);
    bit go;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
    items_sent++;
  endtask

  task automatic send_op(logic [1:0] op, logic [7:0] b, logic [6:0] pin, logic [7:0] mode);
    frp_pkg::in_item_t it;
    it.op = op;
    it.rx_byte = b;
    it.pin_index = pin;
    it.new_mode = mode;
    send_item(it);
  endtask

  task automatic rx(logic [7:0] b);
    send_op(frp_pkg::OP_BYTE, b, 7'($urandom), 8'($urandom));
  endtask

  task automatic read_pin(logic [6:0] pin);
    send_op(frp_pkg::OP_READ, 8'($urandom), pin, 8'($urandom));
  endtask

  task automatic set_mode(logic [6:0] pin, logic [7:0] mode);
    send_op(frp_pkg::OP_MODE, 8'($urandom), pin, mode);
  endtask

  task automatic drain();
    while (tracker.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] data7();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'h7F;
      default: return 8'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [6:0] some_pin();
    return ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(23));
  endfunction

  function automatic logic [7:0] lone_status();
    case ($urandom_range(3))
      0: return 8'h80 | 8'($urandom_range(15));
      1: return 8'hA0 | 8'($urandom_range(31));
      2: return 8'hF1 + 8'($urandom_range(5));
      default: return ($urandom_range(1) ? 8'hF8 : 8'hFA + 8'($urandom_range(5)));
    endcase
  endfunction

  task automatic random_message();
    int k;
    case ($urandom_range(99)) inside
      [0:11]: begin
        rx(ST_ANALOG | 8'($urandom_range(15))); rx(data7()); rx(data7());
      end
      [12:23]: begin
        rx(ST_DIGITAL | 8'($urandom_range(15))); rx(data7()); rx(data7());
      end
      [24:27]: begin
        rx(ST_VERSION); rx(data7()); rx(data7());
      end
      [28:31]: begin
        rx(($urandom_range(1) ? ST_PROGRAM : ST_PRESSURE) | 8'($urandom_range(15)));
        rx(data7());
      end
      [32:37]: begin
        rx(ST_SYSEX); rx(SX_FIRMWARE);
        repeat ($urandom_range(3)) rx(data7());
        rx(ST_END);
      end
      [38:43]: begin
        rx(ST_SYSEX); rx(SX_CAPAB);
        repeat ($urandom_range(10)) begin
          repeat ($urandom_range(3)) begin
            rx(8'($urandom_range(20))); rx(8'($urandom_range(14)));
          end
          if ($urandom_range(5) == 0) rx(8'($urandom_range(20)));
          rx(CAP_PIN_END);
        end
        rx(ST_END);
      end
      [44:49]: begin
        rx(ST_SYSEX); rx(SX_AMAP);
        k = ($urandom_range(9) == 0) ? $urandom_range(140) : $urandom_range(24);
        repeat (k) rx($urandom_range(2) == 0 ? CAP_PIN_END : 8'($urandom_range(17)));
        rx(ST_END);
      end
      [50:59]: begin
        rx(ST_SYSEX); rx(SX_PSTATE); rx(8'(some_pin()));
        rx(8'($urandom_range(1) ? $urandom_range(4) : $urandom_range(127)));
        repeat ($urandom_range(5)) rx(data7());
        rx(ST_END);
      end
      [60:63]: begin
        rx(ST_SYSEX);
        repeat ($urandom_range(6)) rx(data7());
        rx(ST_END);
      end
      [64:77]: read_pin(some_pin());
      [78:87]: set_mode(some_pin(),
                        $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(4)));
      [88:91]: rx(lone_status());
      [92:95]: begin
        rx(ST_ANALOG | 8'($urandom_range(15)));
        if ($urandom_range(1)) rx(data7());
      end
      default: rx(8'($urandom));
    endcase
  endtask

  initial begin
    int phase_gap[4];
    int phase_stall[4];
    phase_gap = '{0, 68, 0, 11};
    phase_stall = '{0, 0, 68, 11};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset entry, mode change before the board is ready, broken and lone messages
    read_pin(7'd0);
    set_mode(7'd5, 8'd1);
    read_pin(7'd127);
    rx(8'h55);
    rx(ST_ANALOG | 8'h0F); rx(8'h7F); rx(8'h7F);
    rx(ST_DIGITAL | 8'h0F); rx(8'h7F); rx(8'h7F);
    rx(ST_VERSION); rx(8'h02); rx(8'h05);
    rx(ST_PROGRAM); rx(8'h00);
    rx(ST_NOTE_OFF);
    rx(8'hFF);
    rx(ST_SYSEX); rx(SX_FIRMWARE); rx(ST_END);
    rx(ST_SYSEX); rx(SX_FIRMWARE); rx(8'h09); rx(ST_END);
    rx(ST_SYSEX); rx(SX_FIRMWARE); rx(8'h02); rx(8'h7F); rx(ST_END);
    set_mode(7'd127, 8'hFF);
    set_mode(7'd0, 8'd0);
    read_pin(7'd0);

    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = phase_gap[ph];
      stall_pct = phase_stall[ph];
      for (int base = items_sent; items_sent < base + 325; ) random_message();
      if (ph == 1) begin
        in_valid <= 1'b0;
        drain();
        @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    gap_pct = 0;
    stall_pct = 0;
    drain();
    repeat (300) @(posedge clk);
    $display("sent %0d items, checked %0d results", items_sent, tracker.results_seen);
    $display("kinds: analog %0d digital %0d firmware %0d caps %0d map %0d state %0d ign %0d",
             tracker.kinds_seen[frp_pkg::K_ANALOG], tracker.kinds_seen[frp_pkg::K_DIGITAL],
             tracker.kinds_seen[frp_pkg::K_FIRMWARE], tracker.kinds_seen[frp_pkg::K_CAPAB],
             tracker.kinds_seen[frp_pkg::K_AMAP], tracker.kinds_seen[frp_pkg::K_PSTATE],
             tracker.kinds_seen[frp_pkg::K_IGNORED]);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", tracker.mismatches,
               tracker.pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end
endmodule
